/* rtl/core/blrs_pkg.sv */
// ----------------------------------------------------------------------------
// blrs_pkg
// Shared codes for the Bresenham line route stepper: operation selectors
// and result kinds.
// ----------------------------------------------------------------------------
package blrs_pkg;

    // Operation selector carried on the input tuser
    localparam logic OP_BEGIN  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    // Result kind carried on the output tuser
    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_ADDED = 2'd1,
        KIND_END   = 2'd2,
        KIND_BLOCK = 2'd3
    } t_kind;

endpackage

/* rtl/core/bresenham_line_route_stepper.sv */
// ----------------------------------------------------------------------------
// bresenham_line_route_stepper
// Walks an integer Bresenham line from a start tile toward an end tile,
// querying each tile after the start and reporting passable tiles as added.
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata (low bit up)                              | tuser | tlast
//  ----------+-----+-------------------------------------------------+-------+------
//  s (in)    | in  | start_x, start_y, end_x, end_y, passable, zeros | op    | -
//  m (out)   | out | tile_x, tile_y, zeros                           | kind  | last
//
//  An item is decoded and the line state stepped in the cycle it is accepted;
//  its results (none, one or two) are pushed into a four-entry result queue
//  and leave one per cycle while the receiver is ready, in the order pushed.
//  The queue occupancy sets the input ready: an item is taken while at
//  least two entries are free, so new items flow while older results wait.
//  Reset is synchronous, active low, and empties the queue and drops any line.
//
module bresenham_line_route_stepper #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // fields from bit 0: start_x, start_y, end_x, end_y, passable
    input  logic [((4*COORD_BITS+8)/8)*8-1:0]      i_s_tdata,
    // fields from bit 0: op
    input  logic                                   i_s_tuser,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // fields from bit 0: tile_x, tile_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      o_m_tdata,
    // fields from bit 0: kind
    output logic [1:0]                             o_m_tuser,
    output logic                                   o_m_tlast,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready
);
    import blrs_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int OUT_W = ((2*CB+7)/8)*8;
    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;

    typedef struct packed {
        t_kind           kind;
        logic [CB-1:0]   x;
        logic [CB-1:0]   y;
        logic            last;
    } t_entry;

    // line state
    logic                 r_line_active, n_line_active;
    logic [CB-1:0]        r_cur_x, n_cur_x;
    logic [CB-1:0]        r_cur_y, n_cur_y;
    logic [CB-1:0]        r_goal_x, n_goal_x;
    logic [CB-1:0]        r_goal_y, n_goal_y;
    logic signed [CB+1:0] r_err, n_err;
    logic [CB-1:0]        r_adx, n_adx;
    logic [CB-1:0]        r_ady, n_ady;
    logic                 r_steep, n_steep;
    logic                 r_xdown, n_xdown;
    logic                 r_ydown, n_ydown;

    // result queue
    t_entry               r_fifo [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]     r_count;

    // input fields
    logic [CB-1:0]        in_sx, in_sy, in_ex, in_ey;
    logic                 in_pass;
    logic                 in_op;
    logic                 s_acc, m_acc;

    // new-line decode
    logic [CB-1:0]        nl_adx, nl_ady;
    logic                 nl_steep, nl_xdown, nl_ydown, nl_same;

    // shared step unit
    logic                 a_begin;
    logic [CB-1:0]        a_x, a_y, a_adx, a_ady;
    logic signed [CB+1:0] a_err;
    logic                 a_steep, a_xdown, a_ydown;
    logic [CB-1:0]        a_major, a_minor;
    logic signed [CB+2:0] a_sum, a_twice, a_major_ext, a_minor_ext;
    logic signed [CB+2:0] a_err_next;
    logic                 a_move;
    logic [CB-1:0]        a_x_step, a_y_step;
    logic [CB-1:0]        adv_x, adv_y;
    logic signed [CB+1:0] adv_err;

    // results of the accepted item
    t_entry               res0, res1;
    logic [1:0]           n_push;
    logic                 at_end;

    assign in_sx   = i_s_tdata[CB-1:0];
    assign in_sy   = i_s_tdata[2*CB-1:CB];
    assign in_ex   = i_s_tdata[3*CB-1:2*CB];
    assign in_ey   = i_s_tdata[4*CB-1:3*CB];
    assign in_pass = i_s_tdata[4*CB];
    assign in_op   = i_s_tuser;

    assign o_s_tready = (r_count <= CNT_W'(DEPTH - 2));
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_count != '0);
    assign m_acc      = o_m_tvalid && i_m_tready;

    // Decode extents and step directions of a new line
    always_comb begin
        nl_adx   = (in_sx < in_ex) ? (in_ex - in_sx) : (in_sx - in_ex);
        nl_ady   = (in_sy < in_ey) ? (in_ey - in_sy) : (in_sy - in_ey);
        nl_steep = (nl_ady > nl_adx);
        nl_xdown = !(in_sx < in_ex);
        nl_ydown = !(in_sy < in_ey);
        nl_same  = (in_sx == in_ex) && (in_sy == in_ey);
    end

    // Select the step unit operands: a fresh line or the running one
    assign a_begin = (in_op == OP_BEGIN);
    assign a_x     = a_begin ? in_sx    : r_cur_x;
    assign a_y     = a_begin ? in_sy    : r_cur_y;
    assign a_err   = a_begin ? '0       : r_err;
    assign a_adx   = a_begin ? nl_adx   : r_adx;
    assign a_ady   = a_begin ? nl_ady   : r_ady;
    assign a_steep = a_begin ? nl_steep : r_steep;
    assign a_xdown = a_begin ? nl_xdown : r_xdown;
    assign a_ydown = a_begin ? nl_ydown : r_ydown;

    // Take one Bresenham step: major axis always, minor axis on error
    always_comb begin
        a_major     = a_steep ? a_ady : a_adx;
        a_minor     = a_steep ? a_adx : a_ady;
        a_major_ext = signed'({3'b000, a_major});
        a_minor_ext = signed'({3'b000, a_minor});
        a_sum       = {a_err[CB+1], a_err} + a_minor_ext;
        a_twice     = a_sum <<< 1;
        a_move      = !(a_twice < a_major_ext);
        a_err_next  = a_move ? (a_sum - a_major_ext) : a_sum;
        adv_err     = signed'(a_err_next[CB+1:0]);
        a_x_step    = a_xdown ? (a_x - CB'(1)) : (a_x + CB'(1));
        a_y_step    = a_ydown ? (a_y - CB'(1)) : (a_y + CB'(1));
        if (a_steep) begin
            adv_y = a_y_step;
            adv_x = a_move ? a_x_step : a_x;
        end else begin
            adv_x = a_x_step;
            adv_y = a_move ? a_y_step : a_y;
        end
    end

    // Work out the next line state and the results of an accepted item
    always_comb begin
        n_line_active = r_line_active;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_goal_x      = r_goal_x;
        n_goal_y      = r_goal_y;
        n_err         = r_err;
        n_adx         = r_adx;
        n_ady         = r_ady;
        n_steep       = r_steep;
        n_xdown       = r_xdown;
        n_ydown       = r_ydown;
        n_push        = 2'd0;
        res0          = '{kind: KIND_QUERY, x: adv_x, y: adv_y, last: 1'b1};
        res1          = '{kind: KIND_QUERY, x: adv_x, y: adv_y, last: 1'b1};
        at_end        = r_steep ? (r_cur_y == r_goal_y) : (r_cur_x == r_goal_x);

        if (s_acc) begin
            if (in_op == OP_BEGIN) begin
                n_goal_x = in_ex;
                n_goal_y = in_ey;
                n_push   = 2'd1;
                if (nl_same) begin
                    n_line_active = 1'b0;
                    res0 = '{kind: KIND_END, x: in_ex, y: in_ey, last: 1'b1};
                end else begin
                    n_line_active = 1'b1;
                    n_adx   = nl_adx;
                    n_ady   = nl_ady;
                    n_steep = nl_steep;
                    n_xdown = nl_xdown;
                    n_ydown = nl_ydown;
                    n_err   = adv_err;
                    n_cur_x = adv_x;
                    n_cur_y = adv_y;
                end
            end else if (r_line_active) begin
                if (!in_pass) begin
                    // blocked tile ends the route
                    n_line_active = 1'b0;
                    n_push = 2'd1;
                    res0 = '{kind: KIND_BLOCK, x: r_cur_x, y: r_cur_y, last: 1'b1};
                end else begin
                    n_push = 2'd2;
                    res0 = '{kind: KIND_ADDED, x: r_cur_x, y: r_cur_y, last: 1'b0};
                    if (at_end) begin
                        n_line_active = 1'b0;
                        res1 = '{kind: KIND_END, x: r_goal_x, y: r_goal_y, last: 1'b1};
                    end else begin
                        n_err   = adv_err;
                        n_cur_x = adv_x;
                        n_cur_y = adv_y;
                    end
                end
            end
        end
    end

    // Hold line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_goal_x      <= '0;
            r_goal_y      <= '0;
            r_err         <= '0;
            r_adx         <= '0;
            r_ady         <= '0;
            r_steep       <= 1'b0;
            r_xdown       <= 1'b0;
            r_ydown       <= 1'b0;
        end else begin
            r_line_active <= n_line_active;
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_goal_x      <= n_goal_x;
            r_goal_y      <= n_goal_y;
            r_err         <= n_err;
            r_adx         <= n_adx;
            r_ady         <= n_ady;
            r_steep       <= n_steep;
            r_xdown       <= n_xdown;
            r_ydown       <= n_ydown;
        end
    end

    // Advance queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(n_push);
            if (m_acc) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(n_push) - CNT_W'(m_acc);
        end
    end

    // Store results; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

    // Drive the queue head
    assign o_m_tdata = OUT_W'({r_fifo[r_rd_ptr].y, r_fifo[r_rd_ptr].x});
    assign o_m_tuser = r_fifo[r_rd_ptr].kind;
    assign o_m_tlast = r_fifo[r_rd_ptr].last;

    // Queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    // Ready only with room for two results
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (r_count <= CNT_W'(DEPTH - 2)))
        else $error("ready without room for two results");

    // An added tile is always followed by another result of the same item
    a_added_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_ADDED)) |-> !o_m_tlast)
        else $error("added tile marked last");

    // Route end results close their item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((o_m_tuser == KIND_END) || (o_m_tuser == KIND_BLOCK)))
        |-> o_m_tlast)
        else $error("route end result not last");

    // A passable answer on a live line pushes a pair of results
    a_pair_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_op == OP_ANSWER) && in_pass && r_line_active)
        |-> (n_push == 2'd2))
        else $error("passable answer did not push two results");

endmodule

/* tb/tb_bresenham_line_route_stepper.sv */
// ----------------------------------------------------------------------------
// tb_bresenham_line_route_stepper
// Self-checking bench for the line route stepper. Streams line begins and
// tile answers into the block, predicts each query, added, end and blocked
// result with an in-bench line walker, and compares every output item in
// order. The sender runs in random bursts and the receiver stalls on its own
// pattern, with one long hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_bresenham_line_route_stepper;
    timeunit 1ns;
    timeprecision 1ps;

    import blrs_pkg::*;

    localparam int CB          = 16;
    localparam int S_W         = ((4*CB+8)/8)*8;
    localparam int M_W         = ((2*CB+7)/8)*8;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int REPORT_CAP  = 200;

    typedef struct packed {
        t_kind           kind;
        logic [CB-1:0]   tile_x;
        logic [CB-1:0]   tile_y;
        logic            last;
    } t_tile_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    // fields from bit 0: start_x, start_y, end_x, end_y, passable
    logic [S_W-1:0]   i_s_tdata = '0;
    // fields from bit 0: op
    logic             i_s_tuser = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    // fields from bit 0: tile_x, tile_y
    logic [M_W-1:0]   o_m_tdata;
    // fields from bit 0: kind
    logic [1:0]       o_m_tuser;
    logic             o_m_tlast;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;

    bresenham_line_route_stepper #(.COORD_BITS(CB)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    // Expected tile results, oldest first
    t_tile_result route_q[$];
    int           err_cnt = 0;
    int           live_items = 0;
    int           burst_left = 0;
    bit           hold_req = 1'b0;

    // Line walker state
    bit            walk_active = 1'b0;
    logic [CB-1:0] walk_x = '0, walk_y = '0, goal_x = '0, goal_y = '0;
    longint        walk_err = 0, span_x = 0, span_y = 0;
    bit            steep = 1'b0, x_down = 1'b0, y_down = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Line walker
    // ------------------------------------------------------------------------

    // Step the major axis, and the minor axis when the error calls for it
    function automatic void walk_advance();
        longint major, minor;
        bit     minor_move;
        major = steep ? span_y : span_x;
        minor = steep ? span_x : span_y;
        minor_move = !(2 * (walk_err + minor) < major);
        walk_err += minor_move ? minor - major : minor;
        if (steep || minor_move) begin
            walk_y = y_down ? walk_y - 1'b1 : walk_y + 1'b1;
        end
        if (!steep || minor_move) begin
            walk_x = x_down ? walk_x - 1'b1 : walk_x + 1'b1;
        end
    endfunction

    function automatic void expect_tile(t_kind kind, logic [CB-1:0] x, logic [CB-1:0] y,
                                        logic last);
        t_tile_result r;
        r.kind   = kind;
        r.tile_x = x;
        r.tile_y = y;
        r.last   = last;
        route_q.push_back(r);
    endfunction

    // Work out the results of one accepted item and update the walker
    function automatic void predict_route_item(logic op, logic [CB-1:0] sx, logic [CB-1:0] sy,
                                               logic [CB-1:0] ex, logic [CB-1:0] ey,
                                               logic pass);
        if (op == OP_BEGIN) begin
            goal_x = ex;
            goal_y = ey;
            if (sx == ex && sy == ey) begin
                walk_active = 1'b0;
                expect_tile(KIND_END, ex, ey, 1'b1);
            end else begin
                span_x   = (sx < ex) ? longint'(ex) - longint'(sx) : longint'(sx) - longint'(ex);
                span_y   = (sy < ey) ? longint'(ey) - longint'(sy) : longint'(sy) - longint'(ey);
                steep    = span_y > span_x;
                x_down   = !(sx < ex);
                y_down   = !(sy < ey);
                walk_err = 0;
                walk_x   = sx;
                walk_y   = sy;
                walk_advance();
                walk_active = 1'b1;
                expect_tile(KIND_QUERY, walk_x, walk_y, 1'b1);
            end
        end else if (walk_active) begin
            if (!pass) begin
                walk_active = 1'b0;
                expect_tile(KIND_BLOCK, walk_x, walk_y, 1'b1);
            end else begin
                expect_tile(KIND_ADDED, walk_x, walk_y, 1'b0);
                if (steep ? (walk_y == goal_y) : (walk_x == goal_x)) begin
                    walk_active = 1'b0;
                    expect_tile(KIND_END, goal_x, goal_y, 1'b1);
                end else begin
                    walk_advance();
                    expect_tile(KIND_QUERY, walk_x, walk_y, 1'b1);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one item, in bursts with random gaps, and predict it once taken
    task automatic send_item(input logic op, input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                             input logic [CB-1:0] ex, input logic [CB-1:0] ey,
                             input logic pass);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tdata  <= {{(S_W-4*CB-1){1'b0}}, pass, ey, ex, sy, sx};
        i_s_tuser  <= op;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        if (op == OP_BEGIN || walk_active) begin
            live_items++;
        end
        predict_route_item(op, sx, sy, ex, ey, pass);
    endtask

    // Begin a line; the passable bit is unused and random
    task automatic send_begin(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                              input logic [CB-1:0] ex, input logic [CB-1:0] ey);
        send_item(OP_BEGIN, sx, sy, ex, ey, 1'($urandom_range(0, 1)));
    endtask

    // Answer the pending tile; the coordinate fields are unused and random
    task automatic send_answer(input logic pass);
        send_item(OP_ANSWER, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom), pass);
    endtask

    // Mostly random coordinates, with the edges of the range now and then
    function automatic logic [CB-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return CB'($urandom);
            end
        endcase
    endfunction

    // Offset a coordinate, mirroring the offset if it would leave the range
    function automatic logic [CB-1:0] reach(logic [CB-1:0] s, int d);
        int e;
        e = int'(s) + d;
        if (e < 0 || e > (1 << CB) - 1) begin
            e = int'(s) - d;
        end
        return e[CB-1:0];
    endfunction

    // Walk one random line: mostly passable answers, some blocks, some drops
    task automatic run_route(input int span, input int step_cap);
        logic [CB-1:0] sx, sy;
        int            dx, dy, steps;
        sx = pick_coord();
        sy = pick_coord();
        dx = 0;
        dy = 0;
        if ($urandom_range(0, 15) != 0) begin
            dx = $urandom_range(0, span);
            dy = $urandom_range(0, span);
            if ($urandom_range(0, 1) == 1) dx = -dx;
            if ($urandom_range(0, 1) == 1) dy = -dy;
        end
        send_begin(sx, sy, reach(sx, dx), reach(sy, dy));
        steps = 0;
        while (walk_active) begin
            // leave the line open so that the next begin drops it
            if ($urandom_range(0, 49) == 0) begin
                return;
            end
            send_answer(steps < step_cap && $urandom_range(0, 19) != 0);
            steps++;
        end
        // stray answer with no line: ignored by the block
        if ($urandom_range(0, 7) == 0) begin
            send_answer(1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: own stall pattern, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int mode, mode_left, hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    0: begin
                        i_m_tready <= 1'b1;
                    end
                    1: begin
                        i_m_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_m_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        i_m_tready <= (mode_left % 3 != 0);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each output item with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tile_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind   = t_kind'(o_m_tuser);
            got.tile_x = o_m_tdata[CB-1:0];
            got.tile_y = o_m_tdata[2*CB-1:CB];
            got.last   = o_m_tlast;
            if (route_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_CAP) begin
                    $display("%0t: unexpected result kind %0d x %0d y %0d last %0d",
                             $time, got.kind, got.tile_x, got.tile_y, got.last);
                end
            end else begin
                want = route_q.pop_front();
                if (got.kind !== want.kind || got.tile_x !== want.tile_x ||
                    got.tile_y !== want.tile_y || got.last !== want.last) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_CAP) begin
                        $write("%0t: mismatch: expected kind %0d x %0d y %0d last %0d,",
                               $time, want.kind, want.tile_x, want.tile_y, want.last);
                        $display(" actual kind %0d x %0d y %0d last %0d",
                                 got.kind, got.tile_x, got.tile_y, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_bresenham_line_route_stepper: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked lines: degenerate, shallow in every direction, steep, range edges, drops
    task automatic test_corner_lines();
        // start equals end, then an answer with no line
        send_begin(16'd0, 16'd0, 16'd0, 16'd0);
        send_answer(1'b1);
        // shallow, both axes up, walked to the end
        send_begin(16'd0, 16'd0, 16'd3, 16'd1);
        repeat (3) send_answer(1'b1);
        // steep across the whole range, both axes down, then blocked
        send_begin(16'hFFFF, 16'hFFFF, 16'hFFFD, 16'h0000);
        send_answer(1'b1);
        send_answer(1'b0);
        // long shallow line dropped by a new vertical line
        send_begin(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        send_answer(1'b1);
        send_begin(16'd10, 16'd10, 16'd10, 16'd12);
        repeat (2) send_answer(1'b1);
        // diagonal, x down and y up
        send_begin(16'd5, 16'd5, 16'd3, 16'd7);
        repeat (2) send_answer(1'b1);
        // one-step horizontal line, x down
        send_begin(16'd100, 16'd7, 16'd99, 16'd7);
        send_answer(1'b1);
        // first tile blocked
        send_begin(16'd7, 16'd100, 16'd7, 16'd101);
        send_answer(1'b0);
        // start equals end at the top of the range
        send_begin(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // Hold the receiver off while the sender keeps offering items
    task automatic test_backpressure();
        int target;
        target = live_items + 40;
        hold_req = 1'b1;
        while (live_items < target) begin
            run_route(8, 1000);
        end
    endtask

    // Random routes: mostly short lines, a few long ones cut short
    task automatic test_random_routes(input int n);
        int target;
        target = live_items + n;
        while (live_items < target) begin
            if ($urandom_range(0, 9) == 0) begin
                run_route(300, 40);
            end else begin
                run_route(12, 1000);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_lines();
        test_backpressure();
        test_random_routes(440);
        i_s_tvalid <= 1'b0;
        while (route_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_bresenham_line_route_stepper: clean");
        end else begin
            $display("tb_bresenham_line_route_stepper: errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/blrs_pkg.sv
rtl/core/bresenham_line_route_stepper.sv
tb/tb_bresenham_line_route_stepper.sv
